@@ design/assert_macros.svh @@
// Assertion macros for the CSV tokenizer; clocked on clk_i, disabled in reset.
// Bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CSVT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("csvt assertion failed");
`define CSVT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csvt assertion failed");
`else
`define CSVT_ASSERT(lbl, prop)
`define CSVT_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

@@ design/csvt_pkg.sv @@
// Shared types and constants of the CSV stream tokenizer.
// No dependencies.
`default_nettype none
package csvt_pkg;

  localparam int unsigned MaxColumns = 1024;
  localparam int unsigned ColBits    = 11;
  localparam int unsigned RecBits    = 16;
  localparam int unsigned MaxRes     = 3;
  localparam int unsigned OutDataW   = 40;

  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChQuote   = 8'h22;

  localparam logic [ColBits-1:0] ColMax = ColBits'(MaxColumns);
  localparam logic [RecBits-1:0] RecMax = '1;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_FEND = 2'd1,
    KIND_REND = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_QUOTE   = 3'd1,
    ERR_AFTERQ  = 3'd2,
    ERR_COUNT   = 3'd3,
    ERR_UNTERM  = 3'd4
  } err_e;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         field_byte;
    logic [ColBits-1:0] col_idx;
    logic [RecBits-1:0] record_index;
    err_e               error_code;
    logic               last_of_run;
  } res_t;

  typedef struct packed {
    logic       inside_quotes;
    logic       quote_pending;
    logic       field_open;
    logic [ColBits-1:0] cur_cols;
    logic [ColBits-1:0] exp_cols;
    logic       first_done;
    logic [RecBits-1:0] rec_cnt;
    logic       err_seen;
  } st_t;

  typedef struct packed {
    logic       ready;
    logic [1:0] count;
  } buf_stat_t;

endpackage
`default_nettype wire

@@ design/csvt_in_reg.sv @@
// Input register of the CSV tokenizer: holds one byte item until the parser takes it.
// Depends on csvt_pkg.
`default_nettype none
module csvt_in_reg import csvt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_valid_i,
  output logic            s_ready_o,
  input  wire logic [7:0] byte_i,
  input  wire logic       eoi_i,
  input  wire logic       take_ready_i,
  output logic            valid_o,
  output logic [7:0]      byte_o,
  output logic            eoi_o,
  output logic            adv_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       eoi_q;

  assign adv_o     = valid_q && take_ready_i;
  assign s_ready_o = !valid_q || adv_o;
  assign valid_o   = valid_q;
  assign byte_o    = byte_q;
  assign eoi_o     = eoi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_valid_i && s_ready_o) begin
      valid_q <= 1'b1;
    end else if (adv_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      byte_q <= byte_i;
      eoi_q  <= eoi_i;
    end
  end

endmodule
`default_nettype wire

@@ design/csvt_parser.sv @@
// Tokenizer state and per-byte decision logic; produces up to three results per byte.
// Depends on csvt_pkg.
`default_nettype none
module csvt_parser import csvt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       adv_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       eoi_i,
  output res_t [MaxRes-1:0] res_o,
  output logic [1:0]      n_o
);

  st_t               st_q, st_d;
  res_t [MaxRes-1:0] res_d;
  logic [1:0]        n_d;
  logic [ColBits-1:0] total_a, total_b;

  always_comb begin
    st_d    = st_q;
    res_d   = '0;
    n_d     = 2'd0;
    total_a = '0;
    total_b = '0;
    if (!st_q.err_seen) begin
      if (st_q.inside_quotes && !st_q.quote_pending) begin
        if (byte_i == ChQuote) begin
          st_d.quote_pending = 1'b1;
        end else begin
          res_d[n_d] = '{KIND_BYTE, byte_i, st_d.cur_cols, st_d.rec_cnt, ERR_NONE, 1'b0};
          n_d = n_d + 2'd1;
        end
      end else if (st_q.inside_quotes && byte_i == ChQuote) begin
        st_d.quote_pending = 1'b0;
        res_d[n_d] = '{KIND_BYTE, byte_i, st_d.cur_cols, st_d.rec_cnt, ERR_NONE, 1'b0};
        n_d = n_d + 2'd1;
      end else if (byte_i == ChComma || byte_i == ChNewline) begin
        res_d[n_d] = '{KIND_FEND, 8'd0, st_d.cur_cols, st_d.rec_cnt, ERR_NONE, 1'b0};
        n_d = n_d + 2'd1;
        if (st_d.cur_cols < ColMax) begin
          st_d.cur_cols = st_d.cur_cols + ColBits'(1);
        end
        st_d.field_open    = 1'b0;
        st_d.inside_quotes = 1'b0;
        st_d.quote_pending = 1'b0;
        if (byte_i == ChNewline) begin
          total_a = st_d.cur_cols;
          if (st_d.first_done && total_a != st_d.exp_cols) begin
            res_d[n_d] = '{KIND_ERR, 8'd0, total_a, st_d.rec_cnt, ERR_COUNT, 1'b0};
            n_d = n_d + 2'd1;
            st_d.err_seen = 1'b1;
          end else begin
            if (!st_d.first_done) begin
              st_d.exp_cols   = total_a;
              st_d.first_done = 1'b1;
            end
            res_d[n_d] = '{KIND_REND, 8'd0, total_a, st_d.rec_cnt, ERR_NONE, 1'b0};
            n_d = n_d + 2'd1;
            st_d.cur_cols = '0;
            if (st_d.rec_cnt < RecMax) begin
              st_d.rec_cnt = st_d.rec_cnt + RecBits'(1);
            end
          end
        end
      end else if (st_q.inside_quotes) begin
        res_d[n_d] = '{KIND_ERR, 8'd0, st_d.cur_cols, st_d.rec_cnt, ERR_AFTERQ, 1'b0};
        n_d = n_d + 2'd1;
        st_d.err_seen = 1'b1;
      end else if (byte_i == ChQuote) begin
        if (st_q.field_open) begin
          res_d[n_d] = '{KIND_ERR, 8'd0, st_d.cur_cols, st_d.rec_cnt, ERR_QUOTE, 1'b0};
          n_d = n_d + 2'd1;
          st_d.err_seen = 1'b1;
        end else begin
          st_d.inside_quotes = 1'b1;
          st_d.field_open    = 1'b1;
        end
      end else begin
        st_d.field_open = 1'b1;
        res_d[n_d] = '{KIND_BYTE, byte_i, st_d.cur_cols, st_d.rec_cnt, ERR_NONE, 1'b0};
        n_d = n_d + 2'd1;
      end

      if (eoi_i && !st_d.err_seen) begin
        if (st_d.inside_quotes && !st_d.quote_pending) begin
          res_d[n_d] = '{KIND_ERR, 8'd0, st_d.cur_cols, st_d.rec_cnt, ERR_UNTERM, 1'b0};
          n_d = n_d + 2'd1;
          st_d.err_seen = 1'b1;
        end else if (st_d.field_open || st_d.cur_cols != '0 || st_d.inside_quotes) begin
          res_d[n_d] = '{KIND_FEND, 8'd0, st_d.cur_cols, st_d.rec_cnt, ERR_NONE, 1'b0};
          n_d = n_d + 2'd1;
          if (st_d.cur_cols < ColMax) begin
            st_d.cur_cols = st_d.cur_cols + ColBits'(1);
          end
          total_b = st_d.cur_cols;
          if (st_d.first_done && total_b != st_d.exp_cols) begin
            res_d[n_d] = '{KIND_ERR, 8'd0, total_b, st_d.rec_cnt, ERR_COUNT, 1'b0};
          end else begin
            res_d[n_d] = '{KIND_REND, 8'd0, total_b, st_d.rec_cnt, ERR_NONE, 1'b0};
          end
          n_d = n_d + 2'd1;
        end
      end
    end
    if (eoi_i) begin
      st_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (adv_i) begin
      st_q <= st_d;
    end
  end

  assign res_o = res_d;
  assign n_o   = n_d;

endmodule
`default_nettype wire

@@ design/csvt_res_buf.sv @@
// Result register of the CSV tokenizer: holds the results of one byte and hands
// them out one per cycle while the receiver is ready. Depends on csvt_pkg.
`default_nettype none
module csvt_res_buf import csvt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire res_t [MaxRes-1:0] res_i,
  input  wire logic [1:0]        n_i,
  input  wire logic              m_ready_i,
  output logic                   m_valid_o,
  output res_t                   m_res_o,
  output buf_stat_t              stat_o
);

  res_t [MaxRes-1:0] res_q;
  res_t [MaxRes-1:0] res_l;
  logic [1:0]        cnt_q;
  logic [1:0]        rd_q;
  logic              take;

  assign m_valid_o    = cnt_q != 2'd0;
  assign take         = m_valid_o && m_ready_i;
  assign m_res_o      = res_q[rd_q];
  assign stat_o.ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_ready_i);
  assign stat_o.count = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 2'd0;
    end else if (load_i) begin
      cnt_q <= n_i;
      rd_q  <= 2'd0;
    end else if (take) begin
      cnt_q <= cnt_q - 2'd1;
      rd_q  <= rd_q + 2'd1;
    end
  end

  always_comb begin
    res_l = res_i;
    for (int i = 0; i < MaxRes; i++) begin
      res_l[i].last_of_run = (2'(i) + 2'd1) == n_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_l;
    end
  end

endmodule
`default_nettype wire

@@ design/csv_stream_tokenizer_unit.sv @@
// Top level of the CSV stream tokenizer: input register, parser, result register.
// Depends on csvt_pkg, csvt_in_reg, csvt_parser, csvt_res_buf and assert_macros.svh.
//
// Usage:
//   Slave stream takes one CSV byte per item: tdata is the byte, tlast marks the
//   last byte of the file. Master stream gives tokens: tuser is the kind (field
//   byte, field end, record end, error), tlast marks the last token of a byte.
//   A byte yields zero to three tokens; tokens leave one per cycle while the receiver is ready.
//   Path: an accepted byte is held in the input register, decoded by the parser
//   and loaded into the result register once that register can take it.
//   Throughput: one byte per cycle while each byte yields at most one token and
//   the receiver is ready; a byte with more tokens holds the input until all but
//   its last token have left the single output port of the result register.
//   After the first error, bytes are consumed silently until the byte marked
//   tlast; that byte returns the parser to its reset state.
//   Reset clears the parser state and drops any held byte or token.
//   When the receiver stalls, the result register holds its tokens, the input
//   register holds one byte, and s_axis_tready falls.
`default_nettype none
`include "assert_macros.svh"
module csv_stream_tokenizer_unit import csvt_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,  // data_byte
  input  wire logic                s_axis_tlast,  // end_of_input
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,  // field_byte, col_idx, record_index, error_code, pad
  output logic [1:0]               m_axis_tuser,  // kind
  output logic                     m_axis_tlast   // last_of_run
);

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              in_eoi;
  logic              adv;
  res_t [MaxRes-1:0] res;
  logic [1:0]        n_res;
  res_t              out_res;
  buf_stat_t         bstat;

  csvt_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .eoi_i        (s_axis_tlast),
    .take_ready_i (bstat.ready),
    .valid_o      (in_valid),
    .byte_o       (in_byte),
    .eoi_o        (in_eoi),
    .adv_o        (adv)
  );

  csvt_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .byte_i (in_byte),
    .eoi_i  (in_eoi),
    .res_o  (res),
    .n_o    (n_res)
  );

  csvt_res_buf u_res_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (adv),
    .res_i     (res),
    .n_i       (n_res),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_res_o   (out_res),
    .stat_o    (bstat)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last_of_run;
  assign m_axis_tdata = {2'b00, out_res.error_code, out_res.record_index,
                         out_res.col_idx, out_res.field_byte};

  `CSVT_ASSERT_IMPL(a_adv_valid, adv, in_valid && (bstat.count == 2'd0 || m_axis_tready))
  `CSVT_ASSERT_IMPL(a_err_code, m_axis_tvalid && out_res.kind == KIND_ERR, out_res.error_code != ERR_NONE)
  `CSVT_ASSERT_IMPL(a_no_code, m_axis_tvalid && out_res.kind != KIND_ERR, out_res.error_code == ERR_NONE)
  `CSVT_ASSERT_IMPL(a_byte_zero, m_axis_tvalid && m_axis_tuser != KIND_BYTE, m_axis_tdata[7:0] == 8'd0)
  `CSVT_ASSERT(a_last_on_final, !(m_axis_tvalid && bstat.count == 2'd1) || m_axis_tlast)

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for csv_stream_tokenizer_unit: CSV bytes go in on the slave stream
// and every token on the master stream is checked against an in-bench tokenizer.
// Depends on csvt_pkg and the tokenizer RTL.
module testbench import csvt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems  = 100;
  localparam int StallLimit   = 5000;
  localparam int DrainCycles  = 20;
  localparam int HoldCycles   = 300;
  localparam int ReportLimit  = 10;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = 8'h00;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;

  csv_stream_tokenizer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  int idle_pct       = 30;
  int hold_req       = 0;
  int hold_left      = 0;
  int fail_count     = 0;
  int bytes_sent     = 0;
  int files_sent     = 0;
  int tokens_checked = 0;
  int random_items   = 0;
  int err_hits[5]    = '{default: 0};

  // tokenizer state
  logic               in_quotes;
  logic               quote_open;
  logic               fld_open;
  logic               first_done;
  logic               halted;
  logic [ColBits-1:0] cur_cols;
  logic [ColBits-1:0] exp_cols;
  logic [RecBits-1:0] rec_cnt;

  res_t run_q[$];
  res_t token_q[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_parser();
    in_quotes  = 1'b0;
    quote_open = 1'b0;
    fld_open   = 1'b0;
    first_done = 1'b0;
    halted     = 1'b0;
    cur_cols   = '0;
    exp_cols   = '0;
    rec_cnt    = '0;
  endfunction

  function automatic void push_token(kind_e k, logic [7:0] b, logic [ColBits-1:0] col,
                                     err_e code);
    res_t t;
    t.kind         = k;
    t.field_byte   = b;
    t.col_idx      = col;
    t.record_index = rec_cnt;
    t.error_code   = code;
    t.last_of_run  = 1'b0;
    run_q.push_back(t);
  endfunction

  function automatic void flag_error(logic [ColBits-1:0] col, err_e code);
    push_token(KIND_ERR, 8'h00, col, code);
    halted = 1'b1;
    err_hits[int'(code)]++;
  endfunction

  function automatic void close_field();
    push_token(KIND_FEND, 8'h00, cur_cols, ERR_NONE);
    if (cur_cols < ColMax) cur_cols++;
    fld_open   = 1'b0;
    in_quotes  = 1'b0;
    quote_open = 1'b0;
  endfunction

  function automatic void close_record();
    logic [ColBits-1:0] total;
    close_field();
    total = cur_cols;
    if (!first_done) begin
      exp_cols   = total;
      first_done = 1'b1;
    end else if (total != exp_cols) begin
      flag_error(total, ERR_COUNT);
      return;
    end
    push_token(KIND_REND, 8'h00, total, ERR_NONE);
    cur_cols = '0;
    if (rec_cnt != RecMax) rec_cnt++;
  endfunction

  function automatic void tokenize_byte(logic [7:0] b, logic eoi);
    res_t t;
    run_q.delete();
    if (!halted) begin
      if (in_quotes && !quote_open) begin
        if (b == ChQuote) quote_open = 1'b1;
        else push_token(KIND_BYTE, b, cur_cols, ERR_NONE);
      end else if (in_quotes) begin
        if (b == ChQuote) begin
          quote_open = 1'b0;
          push_token(KIND_BYTE, b, cur_cols, ERR_NONE);
        end else if (b == ChComma) begin
          close_field();
        end else if (b == ChNewline) begin
          close_record();
        end else begin
          flag_error(cur_cols, ERR_AFTERQ);
        end
      end else begin
        if (b == ChComma) begin
          close_field();
        end else if (b == ChNewline) begin
          close_record();
        end else if (b == ChQuote) begin
          if (fld_open) flag_error(cur_cols, ERR_QUOTE);
          else begin
            in_quotes = 1'b1;
            fld_open  = 1'b1;
          end
        end else begin
          fld_open = 1'b1;
          push_token(KIND_BYTE, b, cur_cols, ERR_NONE);
        end
      end
      if (eoi && !halted) begin
        if (in_quotes && !quote_open) flag_error(cur_cols, ERR_UNTERM);
        else if (fld_open || cur_cols != 0 || in_quotes) close_record();
      end
    end
    foreach (run_q[i]) begin
      t = run_q[i];
      if (i == run_q.size() - 1) t.last_of_run = 1'b1;
      token_q.push_back(t);
    end
    if (eoi) clear_parser();
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eoi;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tokenize_byte(b, eoi);
    bytes_sent++;
    if (eoi) files_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input logic ends_file);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], ends_file && (i == s.len() - 1));
  endtask

  task automatic test_quoted_fields();
    send_text("a,\"b\"\"\n,\",\n", 1'b1);
  endtask

  task automatic test_plain_extremes();
    send_byte(ChNewline, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h0D, 1'b1);
  endtask

  task automatic test_error_cases();
    send_text("ab\"x\n", 1'b1);
    send_text("\"a\"b", 1'b1);
    send_text("a\nb,c\n", 1'b1);
    send_text("\"ab", 1'b1);
    send_text("\"a\"", 1'b1);
    send_text("a,", 1'b1);
  endtask

  task automatic test_backpressure();
    hold_req = HoldCycles;
    for (int i = 0; i < 3; i++) send_text("xy,\"z\",", 1'b0);
    send_text("w\n", 1'b1);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == ChComma || b == ChNewline || b == ChQuote);
    return b;
  endfunction

  task automatic test_random_files();
    logic [7:0] file_q[$];
    logic [7:0] b;
    int ncols, nrecs, cols, len;
    while (random_items < RandomItems) begin
      idle_pct = (random_items > 30 && random_items < 80) ? 0 : 30;
      file_q.delete();
      if ($urandom_range(99) < 15) begin
        len = $urandom_range(1, 8);
        repeat (len) file_q.push_back(8'($urandom_range(255)));
      end else begin
        ncols = $urandom_range(1, 4);
        nrecs = $urandom_range(1, 4);
        for (int r = 0; r < nrecs; r++) begin
          cols = ncols;
          if ($urandom_range(99) < 10) cols = (ncols > 1 && $urandom_range(1)) ? ncols - 1
                                                                             : ncols + 1;
          for (int c = 0; c < cols; c++) begin
            if (c > 0) file_q.push_back(ChComma);
            case ($urandom_range(2))
              1: begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                  file_q.push_back(plain_byte());
                  if (k == 0 && $urandom_range(99) < 5) file_q.push_back(ChQuote);
                end
              end
              2: begin
                file_q.push_back(ChQuote);
                len = $urandom_range(0, 4);
                repeat (len) begin
                  b = 8'($urandom_range(255));
                  file_q.push_back(b);
                  if (b == ChQuote) file_q.push_back(ChQuote);
                end
                file_q.push_back(ChQuote);
                if ($urandom_range(99) < 8) file_q.push_back(plain_byte());
              end
              default: ;
            endcase
          end
          if (r < nrecs - 1 || $urandom_range(1)) file_q.push_back(ChNewline);
        end
        if ($urandom_range(99) < 10) begin
          file_q.push_back(ChQuote);
          file_q.push_back(plain_byte());
        end
      end
      if (file_q.size() == 0) file_q.push_back(ChNewline);
      foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
      random_items += file_q.size();
    end
    idle_pct = 30;
  endtask

  // receiver: random stalls plus a requested hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_tokens
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind         = kind_e'(m_axis_tuser);
      got.field_byte   = m_axis_tdata[7:0];
      got.col_idx      = m_axis_tdata[18:8];
      got.record_index = m_axis_tdata[34:19];
      got.error_code   = err_e'(m_axis_tdata[37:35]);
      got.last_of_run  = m_axis_tlast;
      if (token_q.size() == 0) begin
        fail_count++;
        if (fail_count <= ReportLimit)
          $display("%0t: unexpected token kind=%0d byte=%02h col=%0d rec=%0d err=%0d last=%0d",
                   $realtime, got.kind, got.field_byte, got.col_idx, got.record_index,
                   got.error_code, got.last_of_run);
      end else begin
        want = token_q.pop_front();
        tokens_checked++;
        if (got.kind !== want.kind || got.field_byte !== want.field_byte ||
            got.col_idx !== want.col_idx ||
            got.record_index !== want.record_index ||
            got.error_code !== want.error_code || got.last_of_run !== want.last_of_run) begin
          fail_count++;
          if (fail_count <= ReportLimit) begin
            $display("%0t: token mismatch", $realtime);
            $display("  expected kind=%0d byte=%02h col=%0d rec=%0d err=%0d last=%0d",
                     want.kind, want.field_byte, want.col_idx, want.record_index,
                     want.error_code, want.last_of_run);
            $display("  actual   kind=%0d byte=%02h col=%0d rec=%0d err=%0d last=%0d",
                     got.kind, got.field_byte, got.col_idx, got.record_index,
                     got.error_code, got.last_of_run);
          end
        end
      end
    end
  end

  // end the run if neither side moves an item for too long
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("Timeout: no item moved for %0d cycles, %0d tokens outstanding",
             StallLimit, token_q.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    clear_parser();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_quoted_fields();
    test_plain_extremes();
    test_error_cases();
    test_backpressure();
    test_random_files();
    s_axis_tvalid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Summary: %0d bytes in %0d files, %0d tokens checked, %0d mismatches",
             bytes_sent, files_sent, tokens_checked, fail_count);
    $display("Errors raised: quote %0d, after quote %0d, count %0d, unterminated %0d",
             err_hits[int'(ERR_QUOTE)], err_hits[int'(ERR_AFTERQ)],
             err_hits[int'(ERR_COUNT)], err_hits[int'(ERR_UNTERM)]);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
